// ===== design/clut_pkg.sv =====
// shared constants, types and codes for the color lookup table segment writer
package clut_pkg;

    localparam int ENTRIES   = 256;
    localparam int FRAC_BITS = 16;
    localparam int INT_W     = FRAC_BITS + 1;
    localparam int LOC_W     = $clog2(ENTRIES);
    localparam int LOC_OUT_W = 8;
    localparam int CH_W      = 8;
    localparam int CHANNELS  = 4;
    localparam int CH_IDX_W  = $clog2(CHANNELS);
    localparam int COLOR_W   = CH_W * CHANNELS;
    localparam int NUM_W     = LOC_W + CH_W;
    localparam int DIV_CNT_W = $clog2(CH_W);
    localparam int KIND_W    = 2;

    localparam int IN_BITS   = KIND_W + 2 * INT_W + 2 * COLOR_W;
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = COLOR_W + LOC_OUT_W + 1;
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        REQ_SEGMENT = 2'd0,
        REQ_READ    = 2'd1,
        REQ_CLEAR   = 2'd2
    } req_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP,
        ST_DECIDE,
        ST_INIT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_WRITE,
        ST_READ_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             wr;
        logic             rd;
        logic             clr;
        logic [LOC_W-1:0] addr;
    } mem_req_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [LOC_W-1:0] divisor;
    } div_req_t;

endpackage

// ===== design/clut_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module clut_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  clut_pkg::div_req_t     req,
    output logic                   done,
    output logic [clut_pkg::CH_W-1:0] quot
);
    import clut_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [LOC_W-1:0]     rem_reg, rem_next;
    logic [CH_W-1:0]      sh_reg, sh_next;
    logic [CH_W-1:0]      q_reg, q_next;
    logic [LOC_W-1:0]     dvs_reg, dvs_next;
    logic [LOC_W:0]       trial;
    logic [LOC_W:0]       diff;
    logic                 ge;

    assign trial = {rem_reg, sh_reg[CH_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        q_next    = q_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            // quotient fits in CH_W bits, so the high part is already below the divisor
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = req.dividend[NUM_W-1:CH_W];
            sh_next   = req.dividend[CH_W-1:0];
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[LOC_W-1:0] : trial[LOC_W-1:0];
            q_next   = {q_reg[CH_W-2:0], ge};
            sh_next  = {sh_reg[CH_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(CH_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        q_reg   <= q_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ===== design/clut_mem.sv =====
// color table memory with per-entry valid bits so reset and clear read as zero
module clut_mem (
    input  logic                         clk,
    input  logic                         rst_n,
    input  clut_pkg::mem_req_t           req,
    input  logic [clut_pkg::COLOR_W-1:0] wdata,
    output logic [clut_pkg::COLOR_W-1:0] rdata
);
    import clut_pkg::*;

    logic [COLOR_W-1:0] entry_reg [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [COLOR_W-1:0] rdata_reg;
    logic               rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            entry_reg[req.addr] <= wdata;
        end
        if (req.rd)
        begin
            rdata_reg <= entry_reg[req.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (req.clr)
            begin
                valid_reg <= '0;
            end
            else if (req.wr)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd)
            begin
                rvalid_reg <= valid_reg[req.addr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

// ===== design/color_lut_segment_writer.sv =====
// top level: request sequencer for the rgba color lookup table
//
// one request comes in on the s_ stream and gives exactly one result on the
// m_ stream. s_tdata carries the request kind, two intensities and two colors;
// m_tdata carries the color read, the mapped table location and a status bit.
// kind segment write fills a linear ramp between the two mapped locations,
// kind read returns the entry at the first intensity, kind clear empties the
// table. one request is worked on at a time; s_tready is high only while idle.
// a read passes the map, decide, read-wait and done states; a clear or a
// rejected segment skips read-wait. in a segment write of n > 1 entries each
// byte of each entry goes through one shared 8-step divider and then one
// table write. a single-entry segment skips the divider.
// the result sits in an output register, so a stalled receiver only delays
// the next acceptance once a second result is ready to be loaded.
// after reset the table reads as all zero; there is no sweep, valid bits in
// flip-flops are cleared at once, and a clear request does the same.
module color_lut_segment_writer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // req_type[1:0], intensity_first[18:2], intensity_last[35:19],
    // color_first[67:36], color_last[99:68], zero fill above
    input  logic [clut_pkg::IN_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // color_out[31:0], location_out[39:32], status[40], zero fill above
    output logic [clut_pkg::OUT_W-1:0] m_tdata
);
    import clut_pkg::*;

    localparam int PROD_W  = INT_W + LOC_W;
    localparam int QUO_W   = PROD_W - FRAC_BITS;
    localparam int OUT_PAD = OUT_W - OUT_BITS;

    state_t             state_reg, state_next;
    req_kind_t          kind_reg, kind_next;
    logic [INT_W-1:0]   ifirst_reg, ifirst_next;
    logic [INT_W-1:0]   ilast_reg, ilast_next;
    logic [COLOR_W-1:0] cfirst_reg, cfirst_next;
    logic [COLOR_W-1:0] clast_reg, clast_next;
    logic [LOC_W-1:0]   loc_first_reg, loc_first_next;
    logic [LOC_W-1:0]   loc_last_reg, loc_last_next;
    logic [LOC_W-1:0]   d_reg, d_next;
    logic [LOC_W-1:0]   k_reg, k_next;
    logic [CH_IDX_W-1:0] ch_reg, ch_next;
    logic [NUM_W-1:0]   num_reg [CHANNELS];
    logic [NUM_W-1:0]   num_next [CHANNELS];
    logic [NUM_W-1:0]   delta [CHANNELS];
    logic [COLOR_W-1:0] ramp_reg, ramp_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic               status_reg, status_next;
    logic               m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]   m_data_reg, m_data_next;

    mem_req_t           mem_req;
    logic [COLOR_W-1:0] mem_rdata;
    div_req_t           div_req;
    logic               div_done;
    logic [CH_W-1:0]    div_quot;

    // round(i * (ENTRIES-1)) with intensity clamped to one
    function automatic logic [LOC_W-1:0] map_loc(input logic [INT_W-1:0] i);
        logic [INT_W-1:0]  ic;
        logic [PROD_W-1:0] p;
        logic [QUO_W-1:0]  q;
        ic = (i > INT_W'(1 << FRAC_BITS)) ? INT_W'(1 << FRAC_BITS) : i;
        p  = PROD_W'(ic) * PROD_W'(ENTRIES - 1) + PROD_W'(1 << (FRAC_BITS - 1));
        q  = p[PROD_W-1:FRAC_BITS];
        if (q > QUO_W'(ENTRIES - 1))
        begin
            q = QUO_W'(ENTRIES - 1);
        end
        return q[LOC_W-1:0];
    endfunction

    clut_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .wdata (ramp_reg),
        .rdata (mem_rdata)
    );

    clut_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    // per-channel numerator step (c1 - c0), sign extended
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            logic [CH_W:0] dl;
            dl = {1'b0, clast_reg[c*CH_W +: CH_W]} - {1'b0, cfirst_reg[c*CH_W +: CH_W]};
            delta[c] = {{(NUM_W - CH_W - 1){dl[CH_W]}}, dl};
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        ifirst_next    = ifirst_reg;
        ilast_next     = ilast_reg;
        cfirst_next    = cfirst_reg;
        clast_next     = clast_reg;
        loc_first_next = loc_first_reg;
        loc_last_next  = loc_last_reg;
        d_next         = d_reg;
        k_next         = k_reg;
        ch_next        = ch_reg;
        ramp_next      = ramp_reg;
        color_next     = color_reg;
        status_next    = status_reg;
        m_valid_next   = m_valid_reg & ~m_tready;
        m_data_next    = m_data_reg;
        for (int c = 0; c < CHANNELS; c++)
        begin
            num_next[c] = num_reg[c];
        end
        mem_req          = '0;
        mem_req.addr     = loc_first_reg;
        div_req.start    = 1'b0;
        div_req.dividend = num_reg[ch_reg];
        div_req.divisor  = d_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next   = req_kind_t'(s_tdata[KIND_W-1:0]);
                    ifirst_next = s_tdata[KIND_W +: INT_W];
                    ilast_next  = s_tdata[KIND_W + INT_W +: INT_W];
                    cfirst_next = s_tdata[KIND_W + 2*INT_W +: COLOR_W];
                    clast_next  = s_tdata[KIND_W + 2*INT_W + COLOR_W +: COLOR_W];
                    state_next  = ST_MAP;
                end
            end
            ST_MAP:
            begin
                loc_first_next = map_loc(ifirst_reg);
                loc_last_next  = map_loc(ilast_reg);
                state_next     = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                color_next  = '0;
                status_next = 1'b0;
                case (kind_reg)
                    REQ_SEGMENT:
                    begin
                        if (ifirst_reg > ilast_reg)
                        begin
                            status_next = 1'b1;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            d_next     = loc_last_reg - loc_first_reg;
                            k_next     = '0;
                            state_next = ST_INIT;
                        end
                    end
                    REQ_READ:
                    begin
                        mem_req.rd = 1'b1;
                        state_next = ST_READ_WAIT;
                    end
                    REQ_CLEAR:
                    begin
                        mem_req.clr = 1'b1;
                        state_next  = ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_INIT:
            begin
                ch_next = '0;
                for (int c = 0; c < CHANNELS; c++)
                begin
                    num_next[c]  = NUM_W'(cfirst_reg[c*CH_W +: CH_W]) * NUM_W'(d_reg);
                    // single-entry segment takes the mean of both ends
                    ramp_next[c*CH_W +: CH_W] = CH_W'(({1'b0, cfirst_reg[c*CH_W +: CH_W]}
                        + {1'b0, clast_reg[c*CH_W +: CH_W]}) >> 1);
                end
                state_next = (d_reg == '0) ? ST_WRITE : ST_DIV_START;
            end
            ST_DIV_START:
            begin
                div_req.start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    ramp_next[ch_reg*CH_W +: CH_W] = div_quot;
                    if (ch_reg == CH_IDX_W'(CHANNELS - 1))
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_WRITE:
            begin
                mem_req.wr   = 1'b1;
                mem_req.addr = loc_first_reg + k_reg;
                if (k_reg == d_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    k_next  = k_reg + 1'b1;
                    ch_next = '0;
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        num_next[c] = num_reg[c] + delta[c];
                    end
                    state_next = ST_DIV_START;
                end
            end
            ST_READ_WAIT:
            begin
                color_next = mem_rdata;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{OUT_PAD{1'b0}}, status_reg,
                                    LOC_OUT_W'(loc_first_reg), color_reg};
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        ifirst_reg    <= ifirst_next;
        ilast_reg     <= ilast_next;
        cfirst_reg    <= cfirst_next;
        clast_reg     <= clast_next;
        loc_first_reg <= loc_first_next;
        loc_last_reg  <= loc_last_next;
        d_reg         <= d_next;
        k_reg         <= k_next;
        ch_reg        <= ch_next;
        ramp_reg      <= ramp_next;
        color_reg     <= color_next;
        status_reg    <= status_next;
        m_data_reg    <= m_data_next;
        for (int c = 0; c < CHANNELS; c++)
        begin
            num_reg[c] <= num_next[c];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== design/clut_checker.sv =====
// port-level checks for the color lookup table segment writer, bound to the top level
module clut_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [clut_pkg::OUT_W-1:0] m_tdata
);
    import clut_pkg::*;

    // a result waiting on the receiver is not dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // one request in flight: no acceptance right after an acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction accepted back to back");

    // a rejected segment never carries a color
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[COLOR_W + LOC_OUT_W] |-> m_tdata[COLOR_W-1:0] == '0)
        else $error("rejected segment returned a color");

endmodule

bind color_lut_segment_writer clut_checker u_clut_checker (.*);
